// File: rtl/tlmd_pkg.sv
// Shared types, codes and constants of the type-length message deframer.
package tlmd_pkg;

  localparam int LENGTH_BITS_DEF = 24;

  localparam int TYPE_W     = 8;
  localparam int BYTE_W     = 8;
  localparam int LEN_OUT_W  = 24;
  localparam int TICK_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int HDR_CNT_W  = 3;

  localparam logic [HDR_CNT_W-1:0] HDR_LEN_BYTE0 = 3'd1;
  localparam logic [HDR_CNT_W-1:0] HDR_LEN_BYTE1 = 3'd2;
  localparam logic [HDR_CNT_W-1:0] HDR_LEN_BYTE2 = 3'd3;
  localparam logic [HDR_CNT_W-1:0] HDR_LEN_BYTE3 = 3'd4;

  localparam logic [LEN_OUT_W-1:0] MAX_PAYLOAD_RST   = 24'd131072;
  localparam logic [TYPE_W-1:0]    INVALID_TYPE_RST  = 8'd255;
  localparam logic [TICK_W-1:0]    TIMEOUT_TICKS_RST = 32'd90000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_PAYLOAD   = 2'd0,
    REG_INVALID_TYPE  = 2'd1,
    REG_TIMEOUT_TICKS = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_REJECT  = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef struct packed {
    logic [LEN_OUT_W-1:0] max_payload;
    logic [TYPE_W-1:0]    invalid_type;
    logic [TICK_W-1:0]    timeout_ticks;
  } cfg_t;

endpackage

// File: rtl/tlmd_in_if.sv
// Input item channel: received byte or time tick.
interface tlmd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [tlmd_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

// File: rtl/tlmd_out_if.sv
// Result item channel: payload byte, completion, rejection or timeout.
interface tlmd_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic [tlmd_pkg::TYPE_W-1:0]    msg_type;
  logic [tlmd_pkg::BYTE_W-1:0]    payload_byte;
  logic                           last_of_message;
  logic [tlmd_pkg::LEN_OUT_W-1:0] payload_length;

  modport source (output valid, output kind, output msg_type, output payload_byte,
                  output last_of_message, output payload_length, input ready);
  modport sink   (input valid, input kind, input msg_type, input payload_byte,
                  input last_of_message, input payload_length, output ready);
endinterface

// File: rtl/tlmd_cfg_if.sv
// Configuration write channel: register index and write data.
interface tlmd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tlmd_pkg::CFG_IDX_W-1:0]  index;
  logic [tlmd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/tlmd_regs.sv
// Configuration register file of the deframer.
module tlmd_regs (
  input  logic            clk,
  input  logic            rst_n,
  tlmd_cfg_if.sink        cfg_wr,
  output tlmd_pkg::cfg_t  cfg
);

  tlmd_pkg::cfg_t cfg_r;
  tlmd_pkg::cfg_t cfg_nxt;

  assign cfg_wr.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      unique case (tlmd_pkg::reg_idx_t'(cfg_wr.index))
        tlmd_pkg::REG_MAX_PAYLOAD:   cfg_nxt.max_payload   = cfg_wr.data[tlmd_pkg::LEN_OUT_W-1:0];
        tlmd_pkg::REG_INVALID_TYPE:  cfg_nxt.invalid_type  = cfg_wr.data[tlmd_pkg::TYPE_W-1:0];
        tlmd_pkg::REG_TIMEOUT_TICKS: cfg_nxt.timeout_ticks = cfg_wr.data[tlmd_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_payload   <= tlmd_pkg::MAX_PAYLOAD_RST;
      cfg_r.invalid_type  <= tlmd_pkg::INVALID_TYPE_RST;
      cfg_r.timeout_ticks <= tlmd_pkg::TIMEOUT_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/type_length_message_deframer_unit.sv
// Top level of the type-length message deframer.
//
//   port     | dir | handshake    | carries
//   in_item  | in  | valid/ready  | op, data_byte
//   out_item | out | valid/ready  | kind, msg_type, payload_byte, last_of_message,
//            |     |              | payload_length
//   cfg_wr   | in  | valid/ready  | index, data (cfg_wr.ready is always high)
//
// One item per cycle while no result is stalled. A result shows on out_item the cycle after its item is taken.
// in_item.ready is high while the result register is empty or being drained.
// A stalled result holds the single output register and stops intake.
// Reset is synchronous on rst_n; no clearing pass follows it.
module type_length_message_deframer_unit #(
  parameter int LENGTH_BITS = tlmd_pkg::LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tlmd_in_if.sink    in_item,
  tlmd_out_if.source out_item,
  tlmd_cfg_if.sink   cfg_wr
);

  localparam logic [tlmd_pkg::TICK_W-1:0] LEN_MASK =
    tlmd_pkg::TICK_W'((64'd1 << LENGTH_BITS) - 64'd1);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DEAD    = 2'd2
  } phase_t;

  tlmd_pkg::cfg_t cfg;

  tlmd_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  phase_t                             phase_r, phase_nxt;
  logic [tlmd_pkg::HDR_CNT_W-1:0]     hdr_cnt_r, hdr_cnt_nxt;
  logic [tlmd_pkg::TYPE_W-1:0]        type_r, type_nxt;
  logic [tlmd_pkg::LEN_OUT_W-1:0]     len_r, len_nxt;
  logic [LENGTH_BITS-1:0]             rem_r, rem_nxt;
  logic [tlmd_pkg::TICK_W-1:0]        idle_r, idle_nxt;

  logic                               out_valid_r, out_valid_nxt;
  tlmd_pkg::kind_t                    kind_r, kind_nxt;
  logic [tlmd_pkg::TYPE_W-1:0]        msg_type_r, msg_type_nxt;
  logic [tlmd_pkg::BYTE_W-1:0]        pbyte_r, pbyte_nxt;
  logic                               last_r, last_nxt;
  logic [tlmd_pkg::LEN_OUT_W-1:0]     plen_r, plen_nxt;

  logic                               accept;
  logic                               emit;
  logic [tlmd_pkg::TICK_W-1:0]        len_word;
  logic [tlmd_pkg::TICK_W-1:0]        idle_inc;
  logic                               reject;

  assign in_item.ready = !out_valid_r || out_item.ready;
  assign accept        = in_item.valid && in_item.ready;

  assign len_word = {in_item.data_byte, len_r};
  assign idle_inc = (idle_r == '1) ? idle_r : idle_r + 1'b1;
  assign reject   = (type_r == cfg.invalid_type) || (in_item.data_byte != '0) ||
                    (len_r > cfg.max_payload) || (len_word > LEN_MASK);

  always_comb begin
    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    type_nxt     = type_r;
    len_nxt      = len_r;
    rem_nxt      = rem_r;
    idle_nxt     = idle_r;
    emit         = 1'b0;
    kind_nxt     = tlmd_pkg::KIND_BYTE;
    msg_type_nxt = type_r;
    pbyte_nxt    = '0;
    last_nxt     = 1'b0;
    plen_nxt     = len_r;

    if (accept && (phase_r == PH_HEADER || phase_r == PH_PAYLOAD)) begin
      if (in_item.op == tlmd_pkg::OP_TICK) begin
        idle_nxt = idle_inc;
        if (idle_inc >= cfg.timeout_ticks) begin
          phase_nxt    = PH_DEAD;
          emit         = 1'b1;
          kind_nxt     = tlmd_pkg::KIND_TIMEOUT;
          msg_type_nxt = '0;
          plen_nxt     = '0;
        end
      end else if (phase_r == PH_HEADER) begin
        hdr_cnt_nxt = hdr_cnt_r + 1'b1;
        unique case (hdr_cnt_r)
          tlmd_pkg::HDR_LEN_BYTE0: len_nxt[7:0]   = in_item.data_byte;
          tlmd_pkg::HDR_LEN_BYTE1: len_nxt[15:8]  = in_item.data_byte;
          tlmd_pkg::HDR_LEN_BYTE2: len_nxt[23:16] = in_item.data_byte;
          tlmd_pkg::HDR_LEN_BYTE3: begin
            hdr_cnt_nxt = '0;
            emit        = 1'b1;
            if (reject) begin
              phase_nxt = PH_DEAD;
              kind_nxt  = tlmd_pkg::KIND_REJECT;
            end else if (len_word == '0) begin
              idle_nxt = '0;
              kind_nxt = tlmd_pkg::KIND_EMPTY;
              last_nxt = 1'b1;
              plen_nxt = '0;
            end else begin
              emit      = 1'b0;
              rem_nxt   = len_word[LENGTH_BITS-1:0];
              phase_nxt = PH_PAYLOAD;
            end
          end
          default: begin
            type_nxt = in_item.data_byte;
            len_nxt  = '0;
          end
        endcase
      end else begin
        rem_nxt   = rem_r - 1'b1;
        emit      = 1'b1;
        kind_nxt  = tlmd_pkg::KIND_BYTE;
        pbyte_nxt = in_item.data_byte;
        if (rem_r == LENGTH_BITS'(1)) begin
          last_nxt  = 1'b1;
          phase_nxt = PH_HEADER;
          idle_nxt  = '0;
        end
      end
    end

    out_valid_nxt = emit || (out_valid_r && !out_item.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      hdr_cnt_r   <= '0;
      type_r      <= '0;
      len_r       <= '0;
      rem_r       <= '0;
      idle_r      <= '0;
      out_valid_r <= 1'b0;
      kind_r      <= tlmd_pkg::KIND_BYTE;
      msg_type_r  <= '0;
      pbyte_r     <= '0;
      last_r      <= 1'b0;
      plen_r      <= '0;
    end else begin
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      type_r      <= type_nxt;
      len_r       <= len_nxt;
      rem_r       <= rem_nxt;
      idle_r      <= idle_nxt;
      out_valid_r <= out_valid_nxt;
      if (emit) begin
        kind_r     <= kind_nxt;
        msg_type_r <= msg_type_nxt;
        pbyte_r    <= pbyte_nxt;
        last_r     <= last_nxt;
        plen_r     <= plen_nxt;
      end
    end
  end

  assign out_item.valid           = out_valid_r;
  assign out_item.kind            = kind_r;
  assign out_item.msg_type        = msg_type_r;
  assign out_item.payload_byte    = pbyte_r;
  assign out_item.last_of_message = last_r;
  assign out_item.payload_length  = plen_r;

endmodule
